### hw/rtl/imu_tilt_pkg.sv
package imu_tilt_pkg;

  localparam int unsigned CordicIterDefault = 16;
  localparam int unsigned AtanTableLen = 24;
  localparam int unsigned InDataW = 144;
  localparam int unsigned OutDataW = 80;
  localparam logic [15:0] AlphaReset = 16'd62915;
  localparam logic [15:0] MaxDtReset = 16'd1000;

  typedef enum logic [0:0] {
    CFG_ALPHA = 1'b0,
    CFG_MAX_DT = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAG_SETUP,
    ST_SQRT,
    ST_CORDIC,
    ST_ANGLE,
    ST_GYRO_MUL,
    ST_GYRO_DIV,
    ST_GYRO_ADD,
    ST_BLEND_MUL,
    ST_BLEND_ADD,
    ST_DONE
  } exec_state_e;

  typedef struct packed {
    logic [31:0] time_ms;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [18:0] rate_x;
    logic signed [18:0] rate_y;
    logic signed [18:0] rate_z;
  } sample_t;

  // queue entry: sample plus capped dt worked out in front
  typedef struct packed {
    sample_t smp;
    logic [15:0] dt;
  } job_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_gyro_est;
    logic signed [15:0] pitch_gyro_est;
    logic signed [15:0] yaw_gyro_est;
  } result_t;

  function automatic logic signed [35:0] atan_entry(input logic [4:0] idx);
    logic signed [35:0] v;
    case (idx)
      5'd0: v = 36'sd294912000;
      5'd1: v = 36'sd174096719;
      5'd2: v = 36'sd91987925;
      5'd3: v = 36'sd46694507;
      5'd4: v = 36'sd23437865;
      5'd5: v = 36'sd11730358;
      5'd6: v = 36'sd5866610;
      5'd7: v = 36'sd2933484;
      5'd8: v = 36'sd1466765;
      5'd9: v = 36'sd733385;
      5'd10: v = 36'sd366693;
      5'd11: v = 36'sd183346;
      5'd12: v = 36'sd91673;
      5'd13: v = 36'sd45837;
      5'd14: v = 36'sd22918;
      5'd15: v = 36'sd11459;
      5'd16: v = 36'sd5730;
      5'd17: v = 36'sd2865;
      5'd18: v = 36'sd1432;
      5'd19: v = 36'sd716;
      5'd20: v = 36'sd358;
      5'd21: v = 36'sd179;
      5'd22: v = 36'sd90;
      5'd23: v = 36'sd45;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/imu_tilt_front.sv
module imu_tilt_front import imu_tilt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  sample_t     in_smp_i,
  input  logic [15:0] max_dt_i,
  output logic        job_valid_o,
  input  logic        job_ready_i,
  output job_t        job_o
);

  // one-entry queue holding a sample and its capped dt
  logic        full_q, full_d;
  job_t        job_q;
  logic [31:0] prev_time_q;
  logic [31:0] diff;
  logic        take;

  assign in_ready_o  = !full_q;
  assign take        = in_valid_i && in_ready_o;
  assign diff        = in_smp_i.time_ms - prev_time_q;
  assign job_valid_o = full_q;
  assign job_o       = job_q;

  always_comb begin
    full_d = full_q;
    if (job_ready_i && full_q) full_d = 1'b0;
    if (take) full_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q      <= 1'b0;
      prev_time_q <= '0;
    end else begin
      full_q <= full_d;
      if (take) prev_time_q <= in_smp_i.time_ms;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      job_q.smp <= in_smp_i;
      job_q.dt  <= (diff > {16'd0, max_dt_i}) ? max_dt_i : diff[15:0];
    end
  end

endmodule

### hw/rtl/imu_tilt_back.sv
module imu_tilt_back import imu_tilt_pkg::*; #(
  parameter int unsigned CordicIterations = CordicIterDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  output logic        job_ready_o,
  input  job_t        job_i,
  input  logic [15:0] alpha_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output result_t     res_o
);

  localparam int unsigned NumIter =
      (CordicIterations < AtanTableLen) ? CordicIterations : AtanTableLen;
  localparam logic [4:0] LastIter = 5'(NumIter - 1);

  exec_state_e state_q, state_d;
  job_t        job_q;
  logic        axis_q;       // 0 roll, 1 pitch
  logic [1:0]  gidx_q;       // gyro axis in work
  logic [4:0]  cnt_q;
  // magnitude / isqrt
  logic [41:0] rad_q;
  logic [21:0] root_q;
  logic [43:0] rem_q;
  // cordic
  logic signed [23:0] cx_q, cy_q;
  logic signed [35:0] cz_q;
  logic signed [15:0] acc_roll_q, acc_pitch_q;
  // gyro
  logic signed [35:0] prod_q;
  logic [35:0]        pmag_q;
  logic               pneg_q;
  logic [35:0]        quo_q;
  logic [8:0]         wrap_q;     // whole turns of 36000 in the increment
  logic signed [17:0] dlt_q;      // increment, saturated or reduced mod 36000
  logic signed [15:0] roll_est_q, pitch_est_q, yaw_est_q;
  logic signed [15:0] roll_g_q, pitch_g_q;
  logic signed [35:0] bl_a_q, bl_b_q;
  logic               bsel_q;
  logic               out_valid_q;
  result_t            out_q;
  result_t            res_q;

  logic signed [15:0] ma, mb, num;
  logic signed [31:0] sq_sum;
  logic [43:0]        trial;
  logic signed [23:0] xs, ys;
  logic signed [35:0] zr;
  logic signed [18:0] rate_sel;
  logic signed [15:0] est_sel, angle_sel;
  logic [35:0]        wrap_rem;
  logic [15:0]        mag16;
  logic signed [17:0] gsum;
  logic signed [37:0] bsum;
  logic signed [21:0] bsh;
  logic signed [15:0] bsat;

  assign job_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_comb begin
    ma  = axis_q ? job_q.smp.accel_y : job_q.smp.accel_x;
    mb  = job_q.smp.accel_z;
    num = axis_q ? 16'(-job_q.smp.accel_x) : job_q.smp.accel_y;
    if (axis_q && job_q.smp.accel_x == -16'sd32768) num = 16'sd0;
    sq_sum = 32'(ma * ma) + 32'(mb * mb);
    trial  = {rem_q[41:0], rad_q[41:40]} - {20'd0, root_q, 2'b01};
    xs = cx_q >>> cnt_q;
    ys = cy_q >>> cnt_q;
    zr = cz_q + 36'sd32768;
    case (gidx_q)
      2'd0:    rate_sel = job_q.smp.rate_x;
      2'd1:    rate_sel = job_q.smp.rate_y;
      default: rate_sel = job_q.smp.rate_z;
    endcase
    case (gidx_q)
      2'd0:    est_sel = roll_est_q;
      2'd1:    est_sel = pitch_est_q;
      default: est_sel = yaw_est_q;
    endcase
    angle_sel = bsel_q ? acc_pitch_q : acc_roll_q;
    // yaw keeps the increment mod 36000, roll and pitch a saturated magnitude
    wrap_rem = quo_q - 36'(wrap_q) * 36'd36000;
    mag16 = (gidx_q == 2'd2) ? wrap_rem[15:0] :
            ((|quo_q[35:16]) ? 16'hFFFF : quo_q[15:0]);
    gsum = 18'(est_sel) + dlt_q;
    bsum = 38'(bl_a_q) + 38'(bl_b_q) + 38'sd32768;
    bsh  = bsum[37:16];
    bsat = (bsh > 22'sd18000) ? 16'sd18000 :
           (bsh < -22'sd18000) ? -16'sd18000 : bsh[15:0];
  end

  // negated x only matters for pitch with x = -32768: -(-32768)*16 = 524288
  logic signed [23:0] y_init;
  assign y_init = (axis_q && job_q.smp.accel_x == -16'sd32768) ? 24'sd524288
                                                               : 24'(num) <<< 4;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (job_valid_i) state_d = ST_MAG_SETUP;
      ST_MAG_SETUP: state_d = ST_SQRT;
      ST_SQRT:      if (cnt_q == 5'd20) state_d = ST_CORDIC;
      ST_CORDIC:    if (cnt_q == LastIter || (cx_q == 0 && cy_q == 0)) state_d = ST_ANGLE;
      ST_ANGLE:     state_d = axis_q ? ST_GYRO_MUL : ST_MAG_SETUP;
      ST_GYRO_MUL:  state_d = ST_GYRO_DIV;
      ST_GYRO_DIV:  if (cnt_q == 5'd3) state_d = ST_GYRO_ADD;
      ST_GYRO_ADD:  state_d = (gidx_q == 2'd2) ? ST_BLEND_MUL : ST_GYRO_MUL;
      ST_BLEND_MUL: state_d = ST_BLEND_ADD;
      ST_BLEND_ADD: state_d = bsel_q ? ST_DONE : ST_BLEND_MUL;
      ST_DONE:      if (!out_valid_q || res_ready_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      roll_est_q  <= '0;
      pitch_est_q <= '0;
      yaw_est_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_GYRO_ADD && gidx_q == 2'd2) begin
        yaw_est_q <= (gsum >= 18'sd18000) ? 16'(gsum - 18'sd36000) :
                     (gsum < -18'sd18000) ? 16'(gsum + 18'sd36000) : gsum[15:0];
      end
      if (state_q == ST_DONE && (!out_valid_q || res_ready_i)) begin
        out_valid_q <= 1'b1;
        roll_est_q  <= out_q.roll_angle;
        pitch_est_q <= out_q.pitch_angle;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        job_q  <= job_i;
        axis_q <= 1'b0;
      end
      ST_MAG_SETUP: begin
        rad_q  <= {2'b00, sq_sum, 8'd0};
        root_q <= '0;
        rem_q  <= '0;
        cnt_q  <= '0;
      end
      ST_SQRT: begin
        // restoring square root, one result bit a cycle
        rad_q <= {rad_q[39:0], 2'b00};
        if (!trial[43]) begin
          rem_q  <= trial;
          root_q <= {root_q[20:0], 1'b1};
        end else begin
          rem_q  <= {rem_q[41:0], rad_q[41:40]};
          root_q <= {root_q[20:0], 1'b0};
        end
        if (cnt_q == 5'd20) begin
          cx_q  <= 24'({2'b00, root_q[20:0], !trial[43]});
          cy_q  <= y_init;
          cz_q  <= '0;
          cnt_q <= '0;
        end else begin
          cnt_q <= cnt_q + 5'd1;
        end
      end
      ST_CORDIC: begin
        if (!(cx_q == 0 && cy_q == 0)) begin
          if (cy_q >= 0) begin
            cx_q <= cx_q + ys;
            cy_q <= cy_q - xs;
            cz_q <= cz_q + atan_entry(cnt_q);
          end else begin
            cx_q <= cx_q - ys;
            cy_q <= cy_q + xs;
            cz_q <= cz_q - atan_entry(cnt_q);
          end
        end
        cnt_q <= cnt_q + 5'd1;
      end
      ST_ANGLE: begin
        if (axis_q) acc_pitch_q <= (zr >>> 16) > 36'sd9000 ? 16'sd9000 :
                                   (zr >>> 16) < -36'sd9000 ? -16'sd9000 : 16'(zr >>> 16);
        else acc_roll_q <= (zr >>> 16) > 36'sd9000 ? 16'sd9000 :
                           (zr >>> 16) < -36'sd9000 ? -16'sd9000 : 16'(zr >>> 16);
        axis_q <= 1'b1;
        gidx_q <= 2'd0;
      end
      ST_GYRO_MUL: begin
        prod_q <= 36'(rate_sel * $signed({1'b0, job_q.dt}));
        cnt_q  <= 5'd0;
      end
      ST_GYRO_DIV: begin
        // magnitude rounded, /1000 as /8 then reciprocal of 125, then turns of 36000
        if (cnt_q == 5'd0) begin
          pneg_q <= prod_q[35];
          pmag_q <= (prod_q[35] ? 36'(-prod_q) : prod_q) + 36'd500;
          cnt_q  <= 5'd1;
        end else if (cnt_q == 5'd1) begin
          quo_q <= 36'(({31'd0, pmag_q[35:3]} * 64'd2199023256) >> 38);
          cnt_q <= 5'd2;
        end else if (cnt_q == 5'd2) begin
          wrap_q <= 9'(({40'd0, quo_q[28:5]} * 64'd3817749) >> 32);
          cnt_q  <= 5'd3;
        end else begin
          dlt_q <= pneg_q ? -$signed({2'b00, mag16}) : $signed({2'b00, mag16});
          cnt_q <= 5'd0;
        end
      end
      ST_GYRO_ADD: begin
        if (gidx_q == 2'd0)
          roll_g_q <= (gsum > 18'sd18000) ? 16'sd18000 :
                      (gsum < -18'sd18000) ? -16'sd18000 : gsum[15:0];
        if (gidx_q == 2'd1)
          pitch_g_q <= (gsum > 18'sd18000) ? 16'sd18000 :
                       (gsum < -18'sd18000) ? -16'sd18000 : gsum[15:0];
        if (gidx_q == 2'd2) begin
          out_q.yaw_gyro_est <= (gsum >= 18'sd18000) ? 16'(gsum - 18'sd36000) :
                                (gsum < -18'sd18000) ? 16'(gsum + 18'sd36000) : gsum[15:0];
          bsel_q <= 1'b0;
        end
        gidx_q <= gidx_q + 2'd1;
      end
      ST_BLEND_MUL: begin
        bl_a_q <= 36'($signed({1'b0, alpha_i}) * (bsel_q ? pitch_g_q : roll_g_q));
        bl_b_q <= 36'($signed(18'd65536 - {2'b0, alpha_i}) * angle_sel);
      end
      ST_BLEND_ADD: begin
        if (bsel_q) out_q.pitch_angle <= bsat;
        else out_q.roll_angle <= bsat;
        out_q.roll_gyro_est  <= roll_g_q;
        out_q.pitch_gyro_est <= pitch_g_q;
        bsel_q <= 1'b1;
      end
      ST_DONE: begin
        // result register, loaded only once the previous result has left
        if (!out_valid_q || res_ready_i) res_q <= out_q;
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/imu_tilt_complementary_filter.sv
// per sample: the queue, two 21-step square roots, two CORDIC runs, three gyro steps,
// two blends and the result register; zero accel skips CORDIC; the front holds the
// next sample while the back works, a waiting result stalls the back in its last
// state
// reset: asynchronous active low; clears timestamp and angle state, config to defaults
module imu_tilt_complementary_filter import imu_tilt_pkg::*; #(
  parameter int unsigned CordicIterations = CordicIterDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // time_ms, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z from bit 0
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // roll_angle, pitch_angle, roll_gyro_est, pitch_gyro_est, yaw_gyro_est
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [0:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  logic [15:0] alpha_q, max_dt_q;
  sample_t     smp;
  job_t        job;
  logic        job_valid, job_ready;
  result_t     res;

  // unpack the stream word, first field lowest
  assign smp.time_ms = s_axis_tdata[31:0];
  assign smp.accel_x = s_axis_tdata[47:32];
  assign smp.accel_y = s_axis_tdata[63:48];
  assign smp.accel_z = s_axis_tdata[79:64];
  assign smp.rate_x  = s_axis_tdata[98:80];
  assign smp.rate_y  = s_axis_tdata[117:99];
  assign smp.rate_z  = s_axis_tdata[136:118];

  assign cfg_ready_o = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= AlphaReset;
      max_dt_q <= MaxDtReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ALPHA:  alpha_q  <= cfg_data_i;
        CFG_MAX_DT: max_dt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: accept and work out the capped time step
  imu_tilt_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_smp_i    (smp),
    .max_dt_i    (max_dt_q),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  // back: sqrt, cordic, integrate and blend
  imu_tilt_back #(.CordicIterations(CordicIterations)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .alpha_i     (alpha_q),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {res.yaw_gyro_est, res.pitch_gyro_est, res.roll_gyro_est,
                         res.pitch_angle, res.roll_angle};

endmodule

### tb/imu_tilt_checker.sv
`timescale 1ns / 1ps

module imu_tilt_checker import imu_tilt_pkg::*; #(
  parameter int unsigned CordicIterations = CordicIterDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_o,
  input  logic [0:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  samples_o
);

  localparam longint AngLimit = 18000;

  longint atan_q16 [24] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
    5866610, 2933484, 1466765, 733385, 366693, 183346,
    91673, 45837, 22918, 11459, 5730, 2865,
    1432, 716, 358, 179, 90, 45
  };

  logic [15:0] alpha_q;
  logic [15:0] dt_cap;
  logic [31:0] prev_stamp;
  longint      roll_q, pitch_q, yaw_q;
  result_t     angle_fifo[$];

  assign pending_o = angle_fifo.size();

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint int_sqrt(longint v);
    longint res, bitv;
    res  = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > v) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  // atan2(num, |(a, b)|) in centidegrees by vectoring cordic
  function automatic longint tilt_cdeg(longint num, longint a, longint b);
    longint x, y, z, xs, ys;
    x = int_sqrt((a * a + b * b) <<< 8);
    y = num * 16;
    z = 0;
    if (x == 0 && y == 0) return 0;
    for (int i = 0; i < CordicIterations && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_q16[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_q16[i];
      end
    end
    return clip((z + 32768) >>> 16, -9000, 9000);
  endfunction

  // rate * dt / 1000, rounded half away from zero
  function automatic longint rate_step(longint rate, longint dt);
    longint p;
    p = rate * dt;
    if (p >= 0) return (p + 500) / 1000;
    return -((-p + 500) / 1000);
  endfunction

  function automatic longint mix(longint gyro, longint acc, longint a);
    return clip((a * gyro + (65536 - a) * acc + 32768) >>> 16, -AngLimit, AngLimit);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0]  t, diff;
    longint       ax, ay, az, gx, gy, gz, dt, acc_r, acc_p, rg, pg, yg, rf, pf;
    result_t      exp_r, got_r;
    if (!rst_ni) begin
      alpha_q    <= AlphaReset;
      dt_cap     <= MaxDtReset;
      prev_stamp <= '0;
      roll_q     <= 0;
      pitch_q    <= 0;
      yaw_q      <= 0;
      angle_fifo.delete();
      errors_o   <= 0;
      samples_o  <= 0;
    end else begin
      // register write transaction
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_ALPHA:  alpha_q <= cfg_data_i;
          CFG_MAX_DT: dt_cap  <= cfg_data_i;
          default: ;
        endcase
      end
      // input transaction: predict the result
      if (s_axis_tvalid && s_axis_tready) begin
        t  = s_axis_tdata[31:0];
        ax = longint'($signed(s_axis_tdata[47:32]));
        ay = longint'($signed(s_axis_tdata[63:48]));
        az = longint'($signed(s_axis_tdata[79:64]));
        gx = longint'($signed(s_axis_tdata[98:80]));
        gy = longint'($signed(s_axis_tdata[117:99]));
        gz = longint'($signed(s_axis_tdata[136:118]));
        diff  = t - prev_stamp;
        dt    = (diff > dt_cap) ? longint'(dt_cap) : longint'(diff);
        acc_r = tilt_cdeg(ay, ax, az);
        acc_p = tilt_cdeg(-ax, ay, az);
        rg = clip(roll_q + rate_step(gx, dt), -AngLimit, AngLimit);
        pg = clip(pitch_q + rate_step(gy, dt), -AngLimit, AngLimit);
        yg = (yaw_q + rate_step(gz, dt) + AngLimit) % (2 * AngLimit);
        if (yg < 0) yg = yg + 2 * AngLimit;
        yg = yg - AngLimit;
        rf = mix(rg, acc_r, longint'(alpha_q));
        pf = mix(pg, acc_p, longint'(alpha_q));
        prev_stamp <= t;
        roll_q     <= rf;
        pitch_q    <= pf;
        yaw_q      <= yg;
        exp_r.roll_angle     = rf[15:0];
        exp_r.pitch_angle    = pf[15:0];
        exp_r.roll_gyro_est  = rg[15:0];
        exp_r.pitch_gyro_est = pg[15:0];
        exp_r.yaw_gyro_est   = yg[15:0];
        angle_fifo.push_back(exp_r);
        samples_o <= samples_o + 1;
      end
      // output transaction: compare with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got_r.roll_angle     = m_axis_tdata[15:0];
        got_r.pitch_angle    = m_axis_tdata[31:16];
        got_r.roll_gyro_est  = m_axis_tdata[47:32];
        got_r.pitch_gyro_est = m_axis_tdata[63:48];
        got_r.yaw_gyro_est   = m_axis_tdata[79:64];
        if (angle_fifo.size() == 0) begin
          report_mismatch("unexpected result, roll", got_r.roll_angle, 0);
        end else begin
          exp_r = angle_fifo.pop_front();
          if (got_r.roll_angle != exp_r.roll_angle)
            report_mismatch("roll_angle", got_r.roll_angle, exp_r.roll_angle);
          if (got_r.pitch_angle != exp_r.pitch_angle)
            report_mismatch("pitch_angle", got_r.pitch_angle, exp_r.pitch_angle);
          if (got_r.roll_gyro_est != exp_r.roll_gyro_est)
            report_mismatch("roll_gyro_est", got_r.roll_gyro_est, exp_r.roll_gyro_est);
          if (got_r.pitch_gyro_est != exp_r.pitch_gyro_est)
            report_mismatch("pitch_gyro_est", got_r.pitch_gyro_est, exp_r.pitch_gyro_est);
          if (got_r.yaw_gyro_est != exp_r.yaw_gyro_est)
            report_mismatch("yaw_gyro_est", got_r.yaw_gyro_est, exp_r.yaw_gyro_est);
        end
      end
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import imu_tilt_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainCycles = 150;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // time_ms, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z from bit 0
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // roll_angle, pitch_angle, roll_gyro_est, pitch_gyro_est, yaw_gyro_est from bit 0
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [0:0]          cfg_index_i;
  logic [15:0]         cfg_data_i;

  int          fail_count;
  int          angles_pending;
  int          samples_taken;
  int unsigned cycle_count;
  int unsigned idle_pct;        // sender gap odds per cycle
  int unsigned stall_pct;       // receiver stall odds per cycle
  int unsigned hold_cycles;     // long receiver hold-off request
  int unsigned cfg_writes;
  logic [31:0] now_ms;          // running sample clock

  imu_tilt_complementary_filter DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  imu_tilt_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .errors_o     (fail_count),
    .pending_o    (angles_pending),
    .samples_o    (samples_taken)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog on the whole run
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    int unsigned held;
    m_axis_tready = 1'b0;
    held = 0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0 && held < hold_cycles) begin
        held++;
        m_axis_tready <= 1'b0;
      end else begin
        if (hold_cycles != 0) begin
          hold_cycles = 0;
          held        = 0;
        end
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // one sample transaction; tvalid stays high across back-to-back items
  task automatic send_sample(input logic [31:0] t, input logic signed [15:0] ax,
                             input logic signed [15:0] ay, input logic signed [15:0] az,
                             input logic signed [18:0] gx, input logic signed [18:0] gy,
                             input logic signed [18:0] gz);
    logic [143:0] packed_w;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    packed_w      = {7'd0, gz, gy, gx, az, ay, ax, t};
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= packed_w[InDataW-1:0];
    do @(posedge clk_i); while (!s_axis_tready);
    now_ms = t;
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // all results in, then a margin for the back end to settle
  task automatic wait_drained();
    while (angles_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
  endtask

  task automatic reconfigure(input logic [15:0] alpha, input logic [15:0] max_dt);
    stop_sending();
    wait_drained();
    write_reg(CFG_ALPHA, alpha);
    write_reg(CFG_MAX_DT, max_dt);
  endtask

  function automatic logic signed [18:0] any_rate();
    return 19'($signed($urandom_range(400000)) - 200000);
  endfunction

  // mostly steady 1 kHz samples, some jitter, rare jumps and backward steps
  task automatic send_random(input int unsigned count);
    logic [31:0] t;
    logic signed [15:0] ax, ay, az;
    int unsigned sel;
    for (int unsigned n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 70)      t = now_ms + $urandom_range(1, 3);
      else if (sel < 88) t = now_ms + $urandom_range(0, 2000);
      else if (sel < 95) t = now_ms + $urandom_range(60000, 70000);
      else               t = $urandom;
      if ($urandom_range(3) == 0) begin
        ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
      end else begin
        // gravity-scale readings with noise
        ax = 16'($signed($urandom_range(8000)) - 4000);
        ay = 16'($signed($urandom_range(8000)) - 4000);
        az = 16'($signed($urandom_range(20000)) - 10000);
      end
      send_sample(t, ax, ay, az, any_rate(), any_rate(), any_rate());
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    idle_pct      = 0;
    stall_pct     = 0;
    hold_cycles   = 0;
    cfg_writes    = 0;
    now_ms        = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: first sample after reset takes its dt from a zero timestamp
    send_sample(32'd20, 16'sd0, 16'sd0, 16'sd0, 19'sd200000, -19'sd200000, 19'sd100);
    // zero vector already seen; now axis extremes
    send_sample(32'd21, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 19'sd0, 19'sd0, 19'sd0);
    send_sample(32'd22, -16'sd32768, -16'sd32768, -16'sd32768, 19'sd0, 19'sd0, 19'sd0);
    send_sample(32'd23, -16'sd32768, 16'sd0, 16'sd0, 19'sd1, -19'sd1, 19'sd0);
    send_sample(32'd24, 16'sd0, 16'sh7FFF, 16'sd0, -19'sd1, 19'sd1, 19'sd0);
    send_sample(32'd25, 16'sd0, 16'sd0, 16'sh7FFF, 19'sd0, 19'sd0, 19'sd0);
    send_sample(32'd26, 16'sd0, 16'sd0, -16'sd32768, 19'sd0, 19'sd0, 19'sd0);
    // long gaps drive gyro estimates into saturation and yaw around
    send_sample(32'd5026, 16'sd100, -16'sd100, 16'sd4000,
                19'sd200000, 19'sd200000, 19'sd200000);
    send_sample(32'd9026, 16'sd100, -16'sd100, 16'sd4000,
                -19'sd200000, -19'sd200000, -19'sd200000);
    // backward timestamp and wrap across 2^32
    send_sample(32'd10, 16'sd0, 16'sd1, 16'sd1, 19'sd500, 19'sd500, 19'sd500);
    send_sample(32'hFFFF_FFF0, 16'sd1, 16'sd0, 16'sd1, 19'sd500, 19'sd500, 19'sd500);
    send_sample(32'h0000_0005, 16'sd1, 16'sd0, 16'sd1, 19'sd500, 19'sd500, 19'sd500);
    // ties on the gyro rounding
    send_sample(32'd6, 16'sd0, 16'sd0, 16'sd1, 19'sd500, -19'sd500, 19'sd1500);

    // alpha zero, widest dt: huge yaw steps
    reconfigure(16'd0, 16'hFFFF);
    send_sample(32'd70006, 16'sd3, 16'sd4, 16'sd5, 19'sd200000, -19'sd200000, 19'sd200000);
    send_sample(32'd140006, 16'sd3, 16'sd4, 16'sd5, -19'sd200000, 19'sd200000, 19'sd199999);
    // full alpha with a zero dt limit: gyro estimates hold
    reconfigure(16'hFFFF, 16'd0);
    send_sample(32'd150000, 16'sd1000, -16'sd1000, 16'sd0,
                19'sd200000, 19'sd200000, 19'sd200000);
    send_sample(32'd150500, -16'sd1000, 16'sd1000, 16'sd0,
                -19'sd200000, -19'sd200000, -19'sd200000);
    // back to the reset values before the random part
    reconfigure(AlphaReset, MaxDtReset);

    // random phases; receiver and sender idling vary per phase
    idle_pct = 0;  stall_pct = 0;  send_random(300);
    idle_pct = 80; stall_pct = 0;  send_random(250);
    idle_pct = 0;  stall_pct = 80; send_random(250);
    // long receiver hold-off while samples keep coming
    hold_cycles = 600;
    send_random(20);
    idle_pct = 9; stall_pct = 9; send_random(180);
    // sender pause until every result is back
    stop_sending();
    wait_drained();
    send_random(100);

    reconfigure(16'h0001, 16'd1);
    idle_pct = 0; stall_pct = 0; send_random(150);
    reconfigure(16'd32768, 16'd50);
    idle_pct = 9; stall_pct = 80; send_random(150);
    reconfigure(16'($urandom), 16'($urandom_range(1, 65535)));
    idle_pct = 80; stall_pct = 9; send_random(150);
    reconfigure(16'hFFFF, 16'hFFFF);
    idle_pct = 0; stall_pct = 0; send_random(150);

    stop_sending();
    wait_drained();
    $display("covered %0d samples over %0d register writes, idle and stall mixes, hold-off",
             samples_taken, cfg_writes);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/imu_tilt_pkg.sv
hw/rtl/imu_tilt_front.sv
hw/rtl/imu_tilt_back.sv
hw/rtl/imu_tilt_complementary_filter.sv
tb/imu_tilt_checker.sv
tb/testbench.sv
